>>> rtl/floor_ceiling_texel_caster_macros.svh
// assertion macros shared by the texel caster modules
`ifndef FLOOR_CEILING_TEXEL_CASTER_MACROS_SVH
`define FLOOR_CEILING_TEXEL_CASTER_MACROS_SVH

`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define FCC_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("fcc assertion failed");
// condition implies consequence in the cycle after
`define FCC_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("fcc assertion failed");
`else
`define FCC_ASSERT_NOW(label, clk, rst, cond, cons)
`define FCC_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif

`endif

>>> rtl/fcc_pkg.sv
// shared types and constants of the floor and ceiling texel caster
package fcc_pkg;

  localparam int DEF_SCREEN_WIDTH  = 640;
  localparam int DEF_SCREEN_HEIGHT = 480;
  localparam int DEF_TEX_SIZE      = 64;

  // world offset numerator width and row distance width
  localparam int N_W  = 32;
  localparam int DY_W = 12;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_WR_FLOOR = 2'd0,
    OP_WR_CEIL  = 2'd1,
    OP_RENDER   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_WR_FLOOR = 2'd0,
    KIND_WR_CEIL  = 2'd1,
    KIND_RENDER   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_COSINE = 3'd2,
    REG_SINE   = 3'd3,
    REG_FOCAL  = 3'd4
  } cfg_reg_t;

  // what travels with an item besides the offsets
  typedef struct packed {
    kind_t            kind;
    logic [11:0]      index;
    logic [31:0]      value;
    logic [9:0]       column;
    logic [8:0]       row;
    logic [DY_W-1:0]  dy;
  } tag_t;

  typedef struct packed {
    tag_t                   tag;
    logic signed [N_W-1:0]  nx;
    logic signed [N_W-1:0]  ny;
  } entry_t;

endpackage

>>> rtl/fcc_front.sv
// front end: classifies items and forms the projected offset numerators
`include "floor_ceiling_texel_caster_macros.svh"
module fcc_front import fcc_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int TEX_SIZE      = DEF_TEX_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [11:0]        texel_index,
  input  logic [31:0]        texel_value,
  input  logic [9:0]         pixel_column,
  input  logic [8:0]         pixel_row,
  input  logic signed [15:0] view_cosine,
  input  logic signed [15:0] view_sine,
  input  logic [11:0]        focal_distance,
  output logic               push_valid,
  input  logic               push_ready,
  output entry_t             push_entry
);

  localparam logic [12:0] HALF_H = 13'(SCREEN_HEIGHT / 2);

  logic        keep;
  tag_t        tag_in;
  logic        idx_ok, pix_ok;
  logic signed [13:0] dx2;
  logic signed [12:0] dsig;

  logic        fv;
  tag_t        ftag;
  logic signed [28:0] cd, sd;
  logic signed [29:0] sdx, cdx;
  logic        f_adv;

  // classify the incoming item
  always_comb begin
    idx_ok = {20'b0, texel_index} < 32'(TEX_SIZE * TEX_SIZE);
    pix_ok = ({3'b0, pixel_column} < 13'(SCREEN_WIDTH)) &&
             ({4'b0, pixel_row} < 13'(SCREEN_HEIGHT)) &&
             ({4'b0, pixel_row} > HALF_H);
    keep = 1'b0;
    tag_in.kind = KIND_RENDER;
    case (op_t'(operation))
      OP_WR_FLOOR: begin
        keep = idx_ok;
        tag_in.kind = KIND_WR_FLOOR;
      end
      OP_WR_CEIL: begin
        keep = idx_ok;
        tag_in.kind = KIND_WR_CEIL;
      end
      OP_RENDER: begin
        keep = pix_ok;
        tag_in.kind = KIND_RENDER;
      end
      default: keep = 1'b0;
    endcase
    tag_in.index  = texel_index;
    tag_in.value  = texel_value;
    tag_in.column = pixel_column;
    tag_in.row    = pixel_row;
    tag_in.dy     = DY_W'({4'b0, pixel_row} - HALF_H);
    dx2  = $signed({3'b0, pixel_column, 1'b0}) - $signed(14'(SCREEN_WIDTH));
    dsig = $signed({1'b0, focal_distance});
  end

  assign f_adv    = !fv || push_ready;
  assign in_stall = fv && !push_ready;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (f_adv) begin
      fv <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv && in_valid) begin
      ftag <= tag_in;
      cd   <= view_cosine * dsig;
      sd   <= view_sine * dsig;
      sdx  <= view_sine * dx2;
      cdx  <= view_cosine * dx2;
    end
  end

  // offset numerators toward the queue
  always_comb begin
    push_valid     = fv;
    push_entry.tag = ftag;
    push_entry.nx  = (N_W'(cd) <<< 1) - N_W'(sdx);
    push_entry.ny  = (N_W'(sd) <<< 1) + N_W'(cdx);
  end

  `FCC_ASSERT_NEXT(a_front_hold, clk, rst, fv && !push_ready, fv)

endmodule

>>> rtl/fcc_queue.sv
// short queue between the front end and the divider back end
`include "floor_ceiling_texel_caster_macros.svh"
module fcc_queue import fcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign push_ready = count < (PW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_entry;
  end

  `FCC_ASSERT_NEXT(a_queue_fill, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
  `FCC_ASSERT_NOW(a_queue_bound, clk, rst, count == (PW+1)'(QUEUE_DEPTH), !do_push)

endmodule

>>> rtl/fcc_back.sv
// back end: per-pixel divider pipeline, texel address and texture memories
`include "floor_ceiling_texel_caster_macros.svh"
module fcc_back import fcc_pkg::*; #(
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int TEX_SIZE      = DEF_TEX_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  entry_t             pop_entry,
  input  logic signed [31:0] viewer_pos_x,
  input  logic signed [31:0] viewer_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_column,
  output logic [8:0]         floor_row,
  output logic [8:0]         ceiling_row,
  output logic [31:0]        floor_colour,
  output logic [31:0]        ceiling_colour
);

  localparam int TB     = $clog2(TEX_SIZE);
  localparam int AW     = N_W + TB;
  localparam int QW     = AW + 2;
  localparam int ADDR_W = 2 * TB;
  localparam int DEPTH  = TEX_SIZE * TEX_SIZE;

  logic adv;

  // divider pipeline registers, one quotient bit per stage
  logic             sv   [AW+1];
  tag_t             stag [AW+1];
  logic             snx  [AW+1];
  logic             sny  [AW+1];
  logic [DY_W-1:0]  srx  [AW+1];
  logic [DY_W-1:0]  sry  [AW+1];
  logic [AW-1:0]    sdx  [AW+1];
  logic [AW-1:0]    sdy  [AW+1];

  logic [N_W-1:0] mag_x, mag_y;

  // address stage
  logic              cv;
  tag_t              ctag;
  logic [ADDR_W-1:0] caddr;

  logic [31:0] floor_mem [DEPTH];
  logic [31:0] ceil_mem  [DEPTH];

  function automatic logic [TB-1:0] coord(input logic [AW-1:0] q,
                                          input logic [DY_W-1:0] r,
                                          input logic neg,
                                          input logic signed [31:0] pos);
    logic signed [QW-1:0] sq;
    logic signed [QW-1:0] qz;
    logic                 exact;
    sq = $signed({2'b0, q});
    if (neg) sq = -sq - QW'(r != '0);
    qz = sq + $signed({{2{pos[31]}}, pos, {TB{1'b0}}});
    exact = (r == '0) && (qz[15:0] == '0);
    coord = qz[16+TB-1:16] + TB'(qz[QW-1] && !exact);
  endfunction

  assign adv       = !out_valid || !out_stall;
  assign pop_ready = adv;

  // magnitude of the numerators on entry
  always_comb begin
    mag_x = pop_entry.nx[N_W-1] ? N_W'(-pop_entry.nx) : N_W'(pop_entry.nx);
    mag_y = pop_entry.ny[N_W-1] ? N_W'(-pop_entry.ny) : N_W'(pop_entry.ny);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stag[0] <= pop_entry.tag;
      snx[0]  <= pop_entry.nx[N_W-1];
      sny[0]  <= pop_entry.ny[N_W-1];
      srx[0]  <= '0;
      sry[0]  <= '0;
      sdx[0]  <= {mag_x, {TB{1'b0}}};
      sdy[0]  <= {mag_y, {TB{1'b0}}};
    end
  end

  for (genvar k = 0; k < AW; k++) begin : g_div
    logic [DY_W:0] shx, shy;
    logic          gex, gey;

    // restoring division step for both axes
    always_comb begin
      shx = {srx[k], sdx[k][AW-1]};
      shy = {sry[k], sdy[k][AW-1]};
      gex = shx >= {1'b0, stag[k].dy};
      gey = shy >= {1'b0, stag[k].dy};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stag[k+1] <= stag[k];
        snx[k+1]  <= snx[k];
        sny[k+1]  <= sny[k];
        srx[k+1]  <= gex ? DY_W'(shx - {1'b0, stag[k].dy}) : DY_W'(shx);
        sry[k+1]  <= gey ? DY_W'(shy - {1'b0, stag[k].dy}) : DY_W'(shy);
        sdx[k+1]  <= {sdx[k][AW-2:0], gex};
        sdy[k+1]  <= {sdy[k][AW-2:0], gey};
      end
    end
  end

  // texel address from the truncated and wrapped coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (adv) begin
      cv <= sv[AW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctag <= stag[AW];
      if (stag[AW].kind == KIND_RENDER) begin
        caddr <= {coord(sdy[AW], sry[AW], sny[AW], viewer_pos_y),
                  coord(sdx[AW], srx[AW], snx[AW], viewer_pos_x)};
      end else begin
        caddr <= ADDR_W'(stag[AW].index);
      end
    end
  end

  // texture memories, writes in item order, registered reads feed the output
  always_ff @(posedge clk) begin
    if (adv && cv) begin
      case (ctag.kind)
        KIND_WR_FLOOR: floor_mem[caddr] <= ctag.value;
        KIND_WR_CEIL:  ceil_mem[caddr]  <= ctag.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      floor_colour   <= floor_mem[caddr];
      ceiling_colour <= ceil_mem[caddr];
      out_column     <= ctag.column;
      floor_row      <= ctag.row;
      ceiling_row    <= 9'(13'(SCREEN_HEIGHT - 1) - {4'b0, ctag.row});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cv && (ctag.kind == KIND_RENDER);
    end
  end

  `FCC_ASSERT_NEXT(a_back_emit, clk, rst, adv && cv && ctag.kind == KIND_RENDER, out_valid)
  `FCC_ASSERT_NEXT(a_back_freeze, clk, rst, !adv, sv[AW] == $past(sv[AW]) && cv == $past(cv))

endmodule

>>> rtl/floor_ceiling_texel_caster.sv
// top level: register bank, front end, queue and divider back end
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | operation, texel_index, texel_value,
//          |                      | pixel_column, pixel_row
//  out     | out_valid / out_stall| out_column, floor_row, ceiling_row,
//          |                      | floor_colour, ceiling_colour
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; render results come from
// the bit-per-stage divider by the row distance. Reset clears control state only;
// texture contents are undefined until written. out_stall freezes the back end,
// the four-entry queue absorbs the front end, and in_stall rises only when the
// front register waits on a full queue.
module floor_ceiling_texel_caster import fcc_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int TEX_SIZE      = DEF_TEX_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [11:0] texel_index,
  input  logic [31:0] texel_value,
  input  logic [9:0]  pixel_column,
  input  logic [8:0]  pixel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_column,
  output logic [8:0]  floor_row,
  output logic [8:0]  ceiling_row,
  output logic [31:0] floor_colour,
  output logic [31:0] ceiling_colour,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] viewer_pos_x, viewer_pos_y;
  logic signed [15:0] view_cosine, view_sine;
  logic [11:0]        focal_distance;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  // configuration register bank
  always_ff @(posedge clk) begin
    if (rst) begin
      viewer_pos_x   <= '0;
      viewer_pos_y   <= '0;
      view_cosine    <= 16'sd16384;
      view_sine      <= '0;
      focal_distance <= 12'd320;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_POS_X:  viewer_pos_x   <= cfg_data;
        REG_POS_Y:  viewer_pos_y   <= cfg_data;
        REG_COSINE: view_cosine    <= cfg_data[15:0];
        REG_SINE:   view_sine      <= cfg_data[15:0];
        REG_FOCAL:  focal_distance <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  fcc_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TEX_SIZE     (TEX_SIZE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .texel_index   (texel_index),
    .texel_value   (texel_value),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .view_cosine   (view_cosine),
    .view_sine     (view_sine),
    .focal_distance(focal_distance),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  fcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry)
  );

  fcc_back #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TEX_SIZE     (TEX_SIZE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .viewer_pos_x  (viewer_pos_x),
    .viewer_pos_y  (viewer_pos_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_column    (out_column),
    .floor_row     (floor_row),
    .ceiling_row   (ceiling_row),
    .floor_colour  (floor_colour),
    .ceiling_colour(ceiling_colour)
  );

endmodule

>>> tb/floor_ceiling_texel_caster_checker.sv
// checker for the texel caster: tracks textures and registers, predicts and compares results
module floor_ceiling_texel_caster_checker import fcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [11:0] texel_index,
  input  logic [31:0] texel_value,
  input  logic [9:0]  pixel_column,
  input  logic [8:0]  pixel_row,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_column,
  input  logic [8:0]  floor_row,
  input  logic [8:0]  ceiling_row,
  input  logic [31:0] floor_colour,
  input  logic [31:0] ceiling_colour,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH  = DEF_SCREEN_WIDTH;
  localparam int HEIGHT = DEF_SCREEN_HEIGHT;
  localparam int TEX    = DEF_TEX_SIZE;

  typedef struct packed {
    logic [9:0]  column;
    logic [8:0]  frow;
    logic [8:0]  crow;
    logic [31:0] fcol;
    logic [31:0] ccol;
  } pixel_t;

  logic [31:0] floor_tex [TEX*TEX];
  logic [31:0] ceil_tex [TEX*TEX];
  logic [31:0] pos_x, pos_y;
  logic [15:0] cosine, sine;
  logic [11:0] focal;
  pixel_t      expected_pixels[$];

  // floor point coordinate, truncated toward zero and wrapped into the texture
  function automatic longint texel_coord(longint pos, longint n, longint dy);
    longint num, den, q, r;
    num = (pos * dy + n) * TEX;
    den = dy * 65536;
    q = num / den;
    r = q % TEX;
    if (r < 0) r += TEX;
    return r;
  endfunction

  // project one render transfer onto the floor plane
  function automatic pixel_t cast_pixel(logic [9:0] col, logic [8:0] row);
    pixel_t p;
    longint dy, dx2, c, s, d, tx, ty, addr;
    dy = longint'(row) - HEIGHT / 2;
    dx2 = 2 * longint'(col) - WIDTH;
    c = longint'($signed(cosine));
    s = longint'($signed(sine));
    d = longint'(focal);
    tx = texel_coord(longint'($signed(pos_x)), 2 * c * d - s * dx2, dy);
    ty = texel_coord(longint'($signed(pos_y)), 2 * s * d + c * dx2, dy);
    addr = ty * TEX + tx;
    p.column = col;
    p.frow = row;
    p.crow = 9'(HEIGHT - longint'(row) - 1);
    p.fcol = floor_tex[12'(addr)];
    p.ccol = ceil_tex[12'(addr)];
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    checked = 0;
    pending = 0;
  end

  // register writes, input transfers and result transfers
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      cosine <= 16'd16384;
      sine <= '0;
      focal <= 12'd320;
      expected_pixels.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_POS_X:  pos_x <= cfg_data;
          REG_POS_Y:  pos_y <= cfg_data;
          REG_COSINE: cosine <= cfg_data[15:0];
          REG_SINE:   sine <= cfg_data[15:0];
          REG_FOCAL:  focal <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (operation)
          OP_WR_FLOOR: floor_tex[texel_index] = texel_value;
          OP_WR_CEIL:  ceil_tex[texel_index] = texel_value;
          OP_RENDER: begin
            if (pixel_column < WIDTH && pixel_row < HEIGHT && pixel_row > HEIGHT / 2)
              expected_pixels.push_back(cast_pixel(pixel_column, pixel_row));
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected out_column", 32'(out_column), '0);
        end else begin
          p = expected_pixels.pop_front();
          checked++;
          if (out_column != p.column)
            report("out_column", 32'(out_column), 32'(p.column));
          if (floor_row != p.frow)
            report("floor_row", 32'(floor_row), 32'(p.frow));
          if (ceiling_row != p.crow)
            report("ceiling_row", 32'(ceiling_row), 32'(p.crow));
          if (floor_colour != p.fcol) report("floor_colour", floor_colour, p.fcol);
          if (ceiling_colour != p.ccol) report("ceiling_colour", ceiling_colour, p.ccol);
        end
      end
    end
    pending = expected_pixels.size();
  end
endmodule

>>> tb/floor_ceiling_texel_caster_tb.sv
// testbench top for the texel caster: clock, reset, stimulus and verdict
module floor_ceiling_texel_caster_tb import fcc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 64;
  localparam int PER_VIEW = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [11:0] texel_index = '0;
  logic [31:0] texel_value = '0;
  logic [9:0]  pixel_column = '0;
  logic [8:0]  pixel_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_column;
  logic [8:0]  floor_row, ceiling_row;
  logic [31:0] floor_colour, ceiling_colour;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors, pending, checked;
  int          sent = 0;
  bit          idling = 1'b1;

  // current view, used to keep renders on written texels
  logic [31:0] view_px = '0;
  logic [31:0] view_py = '0;
  logic [15:0] view_c = 16'h4000;
  logic [15:0] view_s = '0;
  logic [11:0] view_d = 12'd320;
  bit          floor_done [4096];
  bit          ceil_done [4096];

  floor_ceiling_texel_caster dut (.*);
  floor_ceiling_texel_caster_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side stalls at random
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= idling && ($urandom_range(99) < 31);
  end

  // wrapped texel coordinate of the floor point
  function automatic longint wrap_coord(longint pos, longint n, longint dy);
    longint q, r;
    q = ((pos * dy + n) * DEF_TEX_SIZE) / (dy * 65536);
    r = q % DEF_TEX_SIZE;
    if (r < 0) r += DEF_TEX_SIZE;
    return r;
  endfunction

  // texel address that an on-screen floor pixel reads
  function automatic logic [11:0] texel_addr(logic [9:0] col, logic [8:0] row);
    longint dy, dx2, c, s, d, tx, ty;
    dy = longint'(row) - DEF_SCREEN_HEIGHT / 2;
    dx2 = 2 * longint'(col) - DEF_SCREEN_WIDTH;
    c = longint'($signed(view_c));
    s = longint'($signed(view_s));
    d = longint'(view_d);
    tx = wrap_coord(longint'($signed(view_px)), 2 * c * d - s * dx2, dy);
    ty = wrap_coord(longint'($signed(view_py)), 2 * s * d + c * dx2, dy);
    return 12'(ty * DEF_TEX_SIZE + tx);
  endfunction

  // one input transfer, sometimes preceded by a random gap
  task automatic send(logic [1:0] op, logic [11:0] idx, logic [31:0] val,
                      logic [9:0] col, logic [8:0] row);
    bit stalled;
    if (op == OP_WR_FLOOR) floor_done[idx] = 1'b1;
    if (op == OP_WR_CEIL) ceil_done[idx] = 1'b1;
    if (idling && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    texel_index <= idx;
    texel_value <= val;
    pixel_column <= col;
    pixel_row <= row;
    do begin
      @(negedge clk) stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  // render, loading the texels it reads first when they are still unwritten
  task automatic render(logic [9:0] col, logic [8:0] row);
    logic [11:0] addr;
    if (col < 10'(DEF_SCREEN_WIDTH) && row < 9'(DEF_SCREEN_HEIGHT) &&
        row > 9'(DEF_SCREEN_HEIGHT / 2)) begin
      addr = texel_addr(col, row);
      if (!floor_done[addr]) send(OP_WR_FLOOR, addr, $urandom, '0, '0);
      if (!ceil_done[addr]) send(OP_WR_CEIL, addr, $urandom, '0, '0);
    end
    send(OP_RENDER, 12'($urandom), $urandom, col, row);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // bring the block to rest, then load all registers
  task automatic set_view(logic [31:0] px, logic [31:0] py, logic [15:0] c,
                          logic [15:0] s, logic [11:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_COSINE, {16'h0, c});
    write_reg(REG_SINE, {16'h0, s});
    write_reg(REG_FOCAL, {20'h0, d});
    cfg_write <= 1'b0;
    view_px = px;
    view_py = py;
    view_c = c;
    view_s = s;
    view_d = d;
  endtask

  // mostly valid floor pixels, with texture updates, off-screen noise and unused codes
  task automatic random_items(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) render(10'($urandom_range(639)), 9'($urandom_range(479, 241)));
      else if (pick < 70) render(10'($urandom), 9'($urandom));
      else if (pick < 82)
        send(OP_WR_FLOOR, 12'($urandom), $urandom, 10'($urandom), 9'($urandom));
      else if (pick < 94)
        send(OP_WR_CEIL, 12'($urandom), $urandom, 10'($urandom), 9'($urandom));
      else send(OP_UNUSED, 12'($urandom), $urandom, 10'($urandom), 9'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: horizon, screen edges, off-screen, unused code, texel extremes
    send(OP_WR_FLOOR, 12'd0, 32'h0, 10'd0, 9'd0);
    send(OP_WR_CEIL, 12'd4095, 32'hffff_ffff, 10'd1023, 9'd511);
    render(10'd0, 9'd240);
    render(10'd0, 9'd241);
    render(10'd639, 9'd241);
    render(10'd0, 9'd479);
    render(10'd639, 9'd479);
    render(10'd320, 9'd300);
    render(10'd640, 9'd300);
    render(10'd1023, 9'd300);
    render(10'd100, 9'd480);
    render(10'd100, 9'd511);
    render(10'd100, 9'd0);
    send(OP_UNUSED, 12'd5, 32'h1234_5678, 10'd100, 9'd300);
    send(OP_WR_FLOOR, 12'd4095, 32'hffff_ffff, 10'd0, 9'd0);
    send(OP_WR_CEIL, 12'd0, 32'h0, 10'd0, 9'd0);
    render(10'd319, 9'd250);

    random_items(PER_VIEW);
    set_view(32'h8000_0000, 32'h7fff_ffff, 16'hc000, 16'h4000, 12'd1);
    random_items(PER_VIEW);
    idling = 1'b0;
    set_view(32'h7fff_ffff, 32'h8000_0000, 16'h0000, 16'hc000, 12'd4095);
    random_items(PER_VIEW);
    idling = 1'b1;
    set_view($urandom, $urandom, 16'h2d41, 16'hd2bf, 12'd2048);
    random_items(PER_VIEW);
    set_view(32'h0001_8000, 32'hfffe_4000, 16'h7fff, 16'h8000, 12'd4095);
    random_items(PER_VIEW);
    set_view($urandom, $urandom, 16'($urandom), 16'($urandom), 12'($urandom));
    random_items(PER_VIEW);
    set_view(32'h0, 32'h0, 16'h4000, 16'h0, 12'd320);
    random_items(PER_VIEW);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d input transfers over 7 view settings", sent);
    $display("checked %0d pixel results against the prediction", checked);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #4ms;
    $display("timeout with %0d results outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/fcc_pkg.sv
rtl/fcc_front.sv
rtl/fcc_queue.sv
rtl/fcc_back.sv
rtl/floor_ceiling_texel_caster.sv
tb/floor_ceiling_texel_caster_checker.sv
tb/floor_ceiling_texel_caster_tb.sv
